@@ rtl/iiea_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iiea_pkg: shared types and constants
// Sizes, operation and status codes, and the shift control that is
// broadcast along the cell row.
// ----------------------------------------------------------------------------
package iiea_pkg;

   localparam int DEPTH      = 32;
   localparam int DATA_WIDTH = 32;
   localparam int OPC_W      = 3;
   localparam int POS_W      = 6;
   localparam int VAL_W      = 32;
   localparam int STAT_W     = 2;
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [OPC_W-1:0] {
      OP_APPEND = 3'd0,
      OP_REMOVE = 3'd1,
      OP_INSERT = 3'd2,
      OP_ERASE  = 3'd3,
      OP_READ   = 3'd4,
      OP_CLEAR  = 3'd5
   } opcode_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef struct packed {
      logic             ins;
      logic             ers;
      logic [CMP_W-1:0] pos;
   } shift_ctrl_type;

endpackage

@@ rtl/iiea_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iiea_cell: one entry of the array
// Holds one entry; takes its left neighbor on insert, its right neighbor on
// erase, the new data at the insert point, and drives its entry on a match.
// ----------------------------------------------------------------------------
module iiea_cell (
   input  logic                               clock,
   input  iiea_pkg::shift_ctrl_type           ctrl,
   input  logic [iiea_pkg::CMP_W-1:0]         idx,
   input  logic [iiea_pkg::DATA_WIDTH-1:0]    new_data,
   input  logic [iiea_pkg::DATA_WIDTH-1:0]    left_data,
   input  logic [iiea_pkg::DATA_WIDTH-1:0]    right_data,
   output logic [iiea_pkg::DATA_WIDTH-1:0]    data,
   output logic [iiea_pkg::DATA_WIDTH-1:0]    rd_data
);

   logic [iiea_pkg::DATA_WIDTH-1:0] data_ff;
   logic [iiea_pkg::DATA_WIDTH-1:0] data_in;

   always_comb begin
      priority if (ctrl.ins && (idx > ctrl.pos)) begin
         data_in = left_data;
      end else if (ctrl.ins && (idx == ctrl.pos)) begin
         data_in = new_data;
      end else if (ctrl.ers && (idx >= ctrl.pos)) begin
         data_in = right_data;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data    = data_ff;
   assign rd_data = (idx == ctrl.pos) ? data_ff : '0;

endmodule

@@ rtl/indexed_insert_erase_array.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_insert_erase_array: ordered array with insert and erase
// Append, remove last, insert, erase, read and clear on a row of entry
// cells that shift the entries from the position onward.
//
//   channel   ports                          transfer when
//   request   start, busy, req_*             start high and busy low
//   response  rsp_valid, rsp_*               rsp_valid high (one cycle)
//
// one operation per cycle: the cell row shifts the affected entries in parallel
// the result appears in the cycle after the request transfer
// busy stays low: every request is taken
// synchronous reset empties the array; entry contents are not cleared
// ----------------------------------------------------------------------------
module indexed_insert_erase_array (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [iiea_pkg::OPC_W-1:0]       req_opcode,
   input  logic [iiea_pkg::POS_W-1:0]       req_position,
   input  logic signed [iiea_pkg::VAL_W-1:0] req_value,
   output logic                             rsp_valid,
   output logic signed [iiea_pkg::VAL_W-1:0] rsp_read_value,
   output logic [iiea_pkg::CNT_W-1:0]       rsp_count,
   output logic [iiea_pkg::STAT_W-1:0]      rsp_status
);

   localparam int DEPTH = iiea_pkg::DEPTH;
   localparam int DW    = iiea_pkg::DATA_WIDTH;
   localparam int CNT_W = iiea_pkg::CNT_W;
   localparam int CMP_W = iiea_pkg::CMP_W;

   logic [CNT_W-1:0]                 cnt_ff;
   logic [CNT_W-1:0]                 cnt_in;
   logic                             valid_ff;
   logic [iiea_pkg::VAL_W-1:0]       rd_ff;
   logic [iiea_pkg::VAL_W-1:0]       rd_in;
   iiea_pkg::status_type             stat_ff;
   iiea_pkg::status_type             stat_in;
   iiea_pkg::shift_ctrl_type         ctrl;
   logic                             accept;
   logic                             full;
   logic [CMP_W-1:0]                 pos_x;
   logic [CMP_W-1:0]                 cnt_x;
   logic [DW-1:0]                    new_data;
   logic [DW-1:0]                    rd_any;
   logic [DW-1:0]                    cell_data [DEPTH];
   logic [DW-1:0]                    cell_rd   [DEPTH];

   assign busy     = 1'b0;
   assign accept   = start && !busy;
   assign full     = (cnt_ff == CNT_W'(DEPTH));
   assign pos_x    = CMP_W'(req_position);
   assign cnt_x    = CMP_W'(cnt_ff);
   assign new_data = DW'($unsigned(req_value));

   always_comb begin
      rd_any = '0;
      for (int i = 0; i < DEPTH; i++) begin
         rd_any = rd_any | cell_rd[i];
      end
   end

   always_comb begin
      ctrl.ins = 1'b0;
      ctrl.ers = 1'b0;
      ctrl.pos = pos_x;
      cnt_in   = cnt_ff;
      rd_in    = '0;
      stat_in  = iiea_pkg::ST_OK;
      if (accept) begin
         unique case (iiea_pkg::opcode_type'(req_opcode))
            iiea_pkg::OP_APPEND: begin
               if (full) begin
                  stat_in = iiea_pkg::ST_FULL;
               end else begin
                  ctrl.ins = 1'b1;
                  ctrl.pos = cnt_x;
                  cnt_in   = cnt_ff + CNT_W'(1);
               end
            end
            iiea_pkg::OP_REMOVE: begin
               if (cnt_ff == '0) begin
                  stat_in = iiea_pkg::ST_EMPTY;
               end else begin
                  cnt_in = cnt_ff - CNT_W'(1);
               end
            end
            iiea_pkg::OP_INSERT: begin
               if (full) begin
                  stat_in = iiea_pkg::ST_FULL;
               end else if (pos_x > cnt_x) begin
                  stat_in = iiea_pkg::ST_RANGE;
               end else begin
                  ctrl.ins = 1'b1;
                  cnt_in   = cnt_ff + CNT_W'(1);
               end
            end
            iiea_pkg::OP_ERASE: begin
               if (pos_x >= cnt_x) begin
                  stat_in = iiea_pkg::ST_RANGE;
               end else begin
                  ctrl.ers = 1'b1;
                  cnt_in   = cnt_ff - CNT_W'(1);
               end
            end
            iiea_pkg::OP_READ: begin
               if (pos_x >= cnt_x) begin
                  stat_in = iiea_pkg::ST_RANGE;
               end else begin
                  rd_in = iiea_pkg::VAL_W'(rd_any);
               end
            end
            iiea_pkg::OP_CLEAR: begin
               cnt_in = '0;
            end
            default: begin
               cnt_in = cnt_ff;
            end
         endcase
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DW-1:0] left_d;
      logic [DW-1:0] right_d;
      if (i == 0) begin : g_first
         assign left_d = new_data;
      end else begin : g_mid
         assign left_d = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_d = cell_data[i];
      end else begin : g_rest
         assign right_d = cell_data[i+1];
      end
      iiea_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .idx        (CMP_W'(i)),
         .new_data   (new_data),
         .left_data  (left_d),
         .right_data (right_d),
         .data       (cell_data[i]),
         .rd_data    (cell_rd[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         valid_ff <= accept;
      end
      rd_ff   <= rd_in;
      stat_ff <= stat_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_read_value = $signed(rd_ff);
   assign rsp_count      = cnt_ff;
   assign rsp_status     = stat_ff;

endmodule
